/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

/* hdl/ecse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecse_pkg
// Types and constants shared by the console escape sequence encoder.
// ----------------------------------------------------------------------------
package ecse_pkg;

  localparam int unsigned BIN_W      = 17;              // row/column + 1 needs 17 bits
  localparam int unsigned BCD_DIGITS = 5;
  localparam int unsigned BCD_W      = BCD_DIGITS * 4;
  localparam int unsigned CONV_STEPS = BIN_W;
  localparam int unsigned STEP_W     = $clog2(CONV_STEPS);
  localparam int unsigned CNT_W      = $clog2(BCD_DIGITS + 1);
  localparam int unsigned SEQ_MAX    = 14;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    ACT_CURSOR = 3'd0,
    ACT_COLOUR = 3'd1,
    ACT_ATTR   = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_VIS    = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_ROOM      = 3'd0,
    CFG_DEFAULT_COLOUR   = 3'd1,
    CFG_BRIGHT_MASK      = 3'd2,
    CFG_BOLD_MASK        = 3'd3,
    CFG_UNDERLINE_MASK   = 3'd4,
    CFG_REVERSE_MASK     = 3'd5,
    CFG_CLEAR_LINE       = 3'd6,
    CFG_CLEAR_SCREEN_END = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] setting_value;
  } req_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;
    logic             step;
    logic             emit;
    logic             last;
    logic [POS_W-1:0] pos;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             fits;
    logic [POS_W-1:0] seq_len;
  } sts_t;

endpackage

/* hdl/ecse_bcd_conv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecse_bcd_conv
// Binary to BCD converter, shift-and-add-3, one input bit per step.
// ----------------------------------------------------------------------------
module ecse_bcd_conv
  import ecse_pkg::*;
(
  input  logic             clk_i,
  input  logic             load_i,
  input  logic [BIN_W-1:0] bin_i,
  input  logic             step_i,
  output logic [BCD_W-1:0] bcd_o
);

  logic [BIN_W-1:0] bin_q;
  logic [BCD_W-1:0] bcd_q;
  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bin_q <= bin_i;
      bcd_q <= '0;
    end else if (step_i) begin
      bcd_q <= {adj[BCD_W-2:0], bin_q[BIN_W-1]};
      bin_q <= {bin_q[BIN_W-2:0], 1'b0};
    end
  end

  assign bcd_o = bcd_q;

endmodule

/* hdl/ecse_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecse_dpath
// Datapath: config registers, request decode, decimal conversion, byte select.
// ----------------------------------------------------------------------------
module ecse_dpath
  import ecse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  req_t                  req_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output result_t               result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBR  = 8'h5B;  // [
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_J    = 8'h4A;
  localparam logic [7:0] CH_2    = 8'h32;
  localparam logic [7:0] CH_5    = 8'h35;
  localparam logic [7:0] CH_QM   = 8'h3F;  // ?
  localparam logic [7:0] CH_LH   = 8'h68;  // h
  localparam logic [7:0] CH_LL   = 8'h6C;  // l

  typedef enum logic [2:0] {
    FIX_CLR_LINE,
    FIX_CLR_END,
    FIX_CLR_ALL,
    FIX_SHOW,
    FIX_HIDE
  } fix_e;

  // config registers
  logic [7:0]  room_q, dflt_colour_q, bright_mask_q;
  logic [31:0] bold_mask_q, ul_mask_q, rev_mask_q, clr_line_q, clr_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q        <= 8'd255;
      dflt_colour_q <= 8'd255;
      bright_mask_q <= 8'd8;
      bold_mask_q   <= 32'd1;
      ul_mask_q     <= 32'd2;
      rev_mask_q    <= 32'd4;
      clr_line_q    <= 32'd1;
      clr_end_q     <= 32'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BUFFER_ROOM:      room_q        <= cfg_wdata_i[7:0];
        CFG_DEFAULT_COLOUR:   dflt_colour_q <= cfg_wdata_i[7:0];
        CFG_BRIGHT_MASK:      bright_mask_q <= cfg_wdata_i[7:0];
        CFG_BOLD_MASK:        bold_mask_q   <= cfg_wdata_i;
        CFG_UNDERLINE_MASK:   ul_mask_q     <= cfg_wdata_i;
        CFG_REVERSE_MASK:     rev_mask_q    <= cfg_wdata_i;
        CFG_CLEAR_LINE:       clr_line_q    <= cfg_wdata_i;
        CFG_CLEAR_SCREEN_END: clr_end_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  function automatic logic [6:0] colour_param(input logic [7:0] c, input logic bg,
                                              input logic [7:0] dflt,
                                              input logic [7:0] bright);
    logic [6:0] base;
    base = bg ? 7'd40 : 7'd30;
    if (c == dflt) begin
      return base + 7'd9;
    end else if ((c & bright) != 8'd0) begin
      return base + 7'd60 + {4'd0, c[2:0]};
    end else begin
      return base + {4'd0, c[2:0]};
    end
  endfunction

  function automatic logic [3:0] bcd_digit(input logic [BCD_W-1:0] bcd,
                                           input logic [CNT_W-1:0] idx);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (idx == CNT_W'(k)) d = bcd[4*k +: 4];
    end
    return d;
  endfunction

  // significant digits, at least one
  function automatic logic [CNT_W-1:0] digit_count(input logic [BCD_W-1:0] bcd);
    logic [CNT_W-1:0] n;
    n = CNT_W'(1);
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (bcd[4*k +: 4] != 4'd0) n = CNT_W'(k + 1);
    end
    return n;
  endfunction

  function automatic logic [POS_W-1:0] fixed_len(input fix_e f);
    logic [POS_W-1:0] n;
    case (f)
      FIX_CLR_LINE, FIX_CLR_END: n = POS_W'(3);
      FIX_CLR_ALL:               n = POS_W'(7);
      default:                   n = POS_W'(6);
    endcase
    return n;
  endfunction

  // tail of a fixed sequence, after the ESC [ prefix
  function automatic logic [7:0] fixed_byte(input fix_e f, input logic [POS_W-1:0] j);
    logic [7:0] b;
    b = CH_ESC;
    case (f)
      FIX_CLR_LINE: b = CH_K;
      FIX_CLR_END:  b = CH_J;
      FIX_CLR_ALL: begin
        case (j)
          4'd0:    b = CH_2;
          4'd1:    b = CH_J;
          4'd2:    b = CH_ESC;
          4'd3:    b = CH_LBR;
          default: b = CH_H;
        endcase
      end
      default: begin
        case (j)
          4'd0:    b = CH_QM;
          4'd1:    b = CH_2;
          4'd2:    b = CH_5;
          default: b = (f == FIX_SHOW) ? CH_LH : CH_LL;
        endcase
      end
    endcase
    return b;
  endfunction

  // request decode
  logic [BIN_W-1:0] a_bin, b_bin, c_bin;
  logic             numeric_d, use_c_d, cursor_d;
  fix_e             fix_d;
  logic [31:0]      v;

  always_comb begin
    v         = req_i.setting_value;
    a_bin     = '0;
    b_bin     = '0;
    c_bin     = '0;
    numeric_d = 1'b0;
    use_c_d   = 1'b0;
    cursor_d  = 1'b0;
    fix_d     = FIX_CLR_LINE;
    case (action_e'(req_i.action))
      ACT_CURSOR: begin
        a_bin     = {1'b0, v[31:16]} + BIN_W'(1);
        b_bin     = {1'b0, v[15:0]} + BIN_W'(1);
        numeric_d = 1'b1;
        cursor_d  = 1'b1;
      end
      ACT_COLOUR: begin
        a_bin     = BIN_W'(colour_param(v[7:0], 1'b0, dflt_colour_q, bright_mask_q));
        b_bin     = BIN_W'(colour_param(v[15:8], 1'b1, dflt_colour_q, bright_mask_q));
        numeric_d = 1'b1;
      end
      ACT_ATTR: begin
        a_bin     = ((v & bold_mask_q) != 32'd0) ? BIN_W'(1) : BIN_W'(22);
        b_bin     = ((v & ul_mask_q) != 32'd0)   ? BIN_W'(4) : BIN_W'(24);
        c_bin     = ((v & rev_mask_q) != 32'd0)  ? BIN_W'(7) : BIN_W'(27);
        numeric_d = 1'b1;
        use_c_d   = 1'b1;
      end
      ACT_CLEAR: begin
        // line code wins when both codes are equal
        if (v == clr_line_q) begin
          fix_d = FIX_CLR_LINE;
        end else if (v == clr_end_q) begin
          fix_d = FIX_CLR_END;
        end else begin
          fix_d = FIX_CLR_ALL;
        end
      end
      ACT_VIS: fix_d = (v != 32'd0) ? FIX_SHOW : FIX_HIDE;
      default: ;
    endcase
  end

  logic numeric_q, use_c_q, cursor_q;
  fix_e fix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      numeric_q <= numeric_d;
      use_c_q   <= use_c_d;
      cursor_q  <= cursor_d;
      fix_q     <= fix_d;
    end
  end

  logic [BCD_W-1:0] bcd_a, bcd_b, bcd_c;

  ecse_bcd_conv u_conv_a (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .bin_i  (a_bin),
    .step_i (cmd_i.step),
    .bcd_o  (bcd_a)
  );

  ecse_bcd_conv u_conv_b (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .bin_i  (b_bin),
    .step_i (cmd_i.step),
    .bcd_o  (bcd_b)
  );

  ecse_bcd_conv u_conv_c (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .bin_i  (c_bin),
    .step_i (cmd_i.step),
    .bcd_o  (bcd_c)
  );

  // sequence layout: ESC [ A ; B [; C] term
  logic [CNT_W-1:0] da, db, dc;
  logic [POS_W-1:0] a_end, b_end, c_end, num_len, j;
  logic [7:0]       term, num_txt, text_byte_d;

  always_comb begin
    da      = digit_count(bcd_a);
    db      = digit_count(bcd_b);
    dc      = use_c_q ? digit_count(bcd_c) : CNT_W'(0);
    a_end   = POS_W'(da);
    b_end   = a_end + POS_W'(1) + POS_W'(db);
    c_end   = b_end + POS_W'(1) + POS_W'(dc);
    num_len = use_c_q ? c_end + POS_W'(3) : b_end + POS_W'(3);
    term    = cursor_q ? CH_H : CH_M;
    j       = cmd_i.pos - POS_W'(2);

    if (j < a_end) begin
      num_txt = {4'h3, bcd_digit(bcd_a, CNT_W'(a_end - POS_W'(1) - j))};
    end else if (j == a_end) begin
      num_txt = CH_SEMI;
    end else if (j < b_end) begin
      num_txt = {4'h3, bcd_digit(bcd_b, CNT_W'(b_end - POS_W'(1) - j))};
    end else if (use_c_q && (j == b_end)) begin
      num_txt = CH_SEMI;
    end else if (use_c_q && (j < c_end)) begin
      num_txt = {4'h3, bcd_digit(bcd_c, CNT_W'(c_end - POS_W'(1) - j))};
    end else begin
      num_txt = term;
    end

    if (cmd_i.pos == POS_W'(0)) begin
      text_byte_d = CH_ESC;
    end else if (cmd_i.pos == POS_W'(1)) begin
      text_byte_d = CH_LBR;
    end else if (numeric_q) begin
      text_byte_d = num_txt;
    end else begin
      text_byte_d = fixed_byte(fix_q, j);
    end
  end

  assign sts_o.seq_len = numeric_q ? num_len : fixed_len(fix_q);
  assign sts_o.fits    = 8'(sts_o.seq_len) < room_q;

  result_t result_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_q.text_byte <= text_byte_d;
      result_q.last_byte <= cmd_i.last;
    end
  end

  assign result_o = result_q;

endmodule

/* hdl/ecse_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ecse_ctrl
// Controller: accepts requests, runs conversion, checks room, streams bytes.
// ----------------------------------------------------------------------------
module ecse_ctrl
  import ecse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] action_i,
  output logic       busy_o,
  output cmd_t       cmd_o,
  input  sts_t       sts_i,
  output logic       strobe_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_CHECK,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              strobe_q, strobe_d;
  logic              act_ok, last;

  assign busy_o = (state_q != ST_IDLE);
  assign act_ok = action_e'(action_i) inside {ACT_CURSOR, ACT_COLOUR, ACT_ATTR,
                                              ACT_CLEAR, ACT_VIS};
  assign last   = (pos_q == sts_i.seq_len - POS_W'(1));

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    pos_d      = pos_q;
    cmd_o      = '0;
    cmd_o.pos  = pos_q;
    cmd_o.last = last;
    case (state_q)
      ST_IDLE: begin
        // unknown actions are taken and dropped here
        if (start_i && act_ok) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.step = 1'b1;
        if (step_q == STEP_W'(CONV_STEPS - 1)) begin
          state_d = ST_CHECK;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_CHECK: begin
        pos_d   = '0;
        state_d = sts_i.fits ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (last) begin
          state_d = ST_IDLE;
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
    strobe_d = cmd_o.emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      pos_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      pos_q    <= pos_d;
      strobe_q <= strobe_d;
    end
  end

  assign strobe_o = strobe_q;

  `ASSERT_CLK(a_strobe_after_emit, clk_i, rst_ni, strobe_q |-> $past(state_q == ST_EMIT), "strobe without emit cycle")
  `ASSERT_CLK(a_last_ends_emit, clk_i, rst_ni, (state_q == ST_EMIT && last) |=> (state_q == ST_IDLE), "emit did not stop at last byte")
  `ASSERT_CLK(a_pos_in_range, clk_i, rst_ni, (state_q == ST_EMIT) |-> (pos_q < POS_W'(SEQ_MAX)), "byte position beyond sequence limit")
  `ASSERT_NEVER(a_no_strobe_in_conv, clk_i, rst_ni, (state_q == ST_CONV) && strobe_q, "strobe during conversion")

endmodule

/* hdl/console_escape_sequence_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_escape_sequence_encoder
// Turns one console setting request into an ECMA-48 escape sequence, one
// ASCII byte per result, last byte flagged.
// ----------------------------------------------------------------------------
//  channel   | handshake                     | payload
//  ----------+-------------------------------+------------------------------
//  request   | start & !busy                 | req_i   (action, setting_value)
//  result    | result_strobe_o, one cycle    | result_o (text_byte, last_byte)
//  config    | cfg_we_i                      | cfg_idx_i, cfg_wdata_i
//
// A request runs the bit-serial BCD converters, then a room check, then emits
// the L bytes of the sequence one at a time, L up to 14. Results trail the
// byte selection by one register stage. Unknown actions are taken without
// raising busy; dropped sequences end after the room check. Reset is
// asynchronous and restores config defaults.
// The receiver cannot stall: every strobed result is a finished transaction.
// ----------------------------------------------------------------------------
module console_escape_sequence_encoder
  import ecse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  result_strobe_o,
  output result_t               result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  ecse_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (req_i.action),
    .busy_o   (busy),
    .cmd_o    (cmd),
    .sts_i    (sts),
    .strobe_o (result_strobe_o)
  );

  ecse_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule
